>>> hdl/stok_pkg.sv
// Shared types, constants and scanning functions for the source tokenizer.
`timescale 1ns / 1ps
package stok_pkg;

	localparam int WORD_BUFFER_BYTES = 6;
	localparam int WLEN_W = $clog2(WORD_BUFFER_BYTES + 2);
	localparam int KW_COUNT = 12;
	localparam int KW_MAX_LEN = 6;
	localparam int MAX_RESULTS = 4;

	localparam logic [23:0] OFF_CAP  = 24'hFFFFFF;
	localparam logic [15:0] LINE_CAP = 16'hFFFF;
	localparam logic [15:0] COL_CAP  = 16'hFFFF;

	localparam logic [3:0] M_IDLE       = 4'd0;
	localparam logic [3:0] M_LINE_C     = 4'd1;
	localparam logic [3:0] M_BLOCK_C    = 4'd2;
	localparam logic [3:0] M_BLOCK_STAR = 4'd3;
	localparam logic [3:0] M_SLASH      = 4'd4;
	localparam logic [3:0] M_MINUS      = 4'd5;
	localparam logic [3:0] M_WORD       = 4'd6;
	localparam logic [3:0] M_INT        = 4'd7;
	localparam logic [3:0] M_DOT        = 4'd8;
	localparam logic [3:0] M_FRAC       = 4'd9;
	localparam logic [3:0] M_EXP_E      = 4'd10;
	localparam logic [3:0] M_EXP_SIGN   = 4'd11;
	localparam logic [3:0] M_EXP_DIG    = 4'd12;

	localparam logic [5:0] K_EOF      = 6'd0;
	localparam logic [5:0] K_IDENT    = 6'd1;
	localparam logic [5:0] K_INT      = 6'd2;
	localparam logic [5:0] K_FLOAT    = 6'd3;
	localparam logic [5:0] K_KW_FIRST = 6'd4;
	localparam logic [5:0] K_PLUS     = 6'd16;
	localparam logic [5:0] K_MINUS    = 6'd17;
	localparam logic [5:0] K_STAR     = 6'd18;
	localparam logic [5:0] K_SLASH    = 6'd19;
	localparam logic [5:0] K_EQUALS   = 6'd20;
	localparam logic [5:0] K_SEMI     = 6'd21;
	localparam logic [5:0] K_COMMA    = 6'd22;
	localparam logic [5:0] K_COLON    = 6'd23;
	localparam logic [5:0] K_ARROW    = 6'd24;
	localparam logic [5:0] K_LPAREN   = 6'd25;
	localparam logic [5:0] K_RPAREN   = 6'd26;
	localparam logic [5:0] K_LBRACE   = 6'd27;
	localparam logic [5:0] K_RBRACE   = 6'd28;
	localparam logic [5:0] K_LBRACKET = 6'd29;
	localparam logic [5:0] K_RBRACKET = 6'd30;
	localparam logic [5:0] K_LESS     = 6'd31;
	localparam logic [5:0] K_GREATER  = 6'd32;
	localparam logic [5:0] K_UNKNOWN  = 6'd33;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Keyword text, left justified, first byte in the top bits.
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		"fn    ", "let   ", "cast  ", "true  ", "false ", "tensor",
		"f32   ", "f16   ", "bf16  ", "i32   ", "i8    ", "bool  "
	};
	localparam logic [WLEN_W-1:0] KW_LEN [KW_COUNT] = '{
		WLEN_W'(2), WLEN_W'(3), WLEN_W'(4), WLEN_W'(4), WLEN_W'(5), WLEN_W'(6),
		WLEN_W'(3), WLEN_W'(3), WLEN_W'(4), WLEN_W'(3), WLEN_W'(2), WLEN_W'(4)
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [23:0] off;
		logic [23:0] len;
		logic [15:0] line;
		logic [15:0] col;
	} tok_rec_t;

	typedef struct packed {
		logic [3:0]                          mode;
		logic [1:0][7:0]                     held;
		logic [1:0]                          hcnt;
		logic [23:0]                         tb_off;
		logic [15:0]                         tb_line;
		logic [15:0]                         tb_col;
		logic [23:0]                         off;
		logic [15:0]                         line;
		logic [15:0]                         col;
		logic [WORD_BUFFER_BYTES-1:0][7:0]   word;
		logic [WLEN_W-1:0]                   wlen;
		logic                                isf;
	} scan_st_t;

	// Scanner state after reset: between tokens at offset 0, line 1, column 1.
	localparam scan_st_t ST_RESET = '{
		mode: M_IDLE, held: '0, hcnt: 2'd0,
		tb_off: 24'd0, tb_line: 16'd1, tb_col: 16'd1,
		off: 24'd0, line: 16'd1, col: 16'd1,
		word: '0, wlen: '0, isf: 1'b0
	};

	typedef struct packed {
		tok_rec_t [MAX_RESULTS-1:0] rec;
		logic [2:0]                 n;
	} tok_batch_t;

	typedef struct packed {
		scan_st_t   st;
		tok_batch_t b;
	} scan_work_t;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_start(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_word_part(logic [7:0] c);
		return is_word_start(c) || is_digit(c);
	endfunction

	function automatic scan_st_t advance(scan_st_t s, logic [7:0] c);
		if (s.off < OFF_CAP) s.off = s.off + 24'd1;
		if (c == CH_LF) begin
			if (s.line < LINE_CAP) s.line = s.line + 16'd1;
			s.col = 16'd1;
		end else if (s.col < COL_CAP) begin
			s.col = s.col + 16'd1;
		end
		return s;
	endfunction

	function automatic scan_work_t emit(scan_work_t w, logic [5:0] kind, logic [23:0] off,
			logic [23:0] len, logic [15:0] line, logic [15:0] col);
		if (w.b.n < 3'(MAX_RESULTS)) begin
			w.b.rec[w.b.n[1:0]] = '{kind: kind, off: off, len: len, line: line, col: col};
			w.b.n = w.b.n + 3'd1;
		end
		return w;
	endfunction

	function automatic scan_work_t emit_token(scan_work_t w, logic [5:0] kind);
		logic [23:0] len;
		len = (w.st.off >= w.st.tb_off) ? w.st.off - w.st.tb_off : 24'd0;
		return emit(w, kind, w.st.tb_off, len, w.st.tb_line, w.st.tb_col);
	endfunction

	function automatic logic [5:0] word_kind(scan_st_t s);
		logic [5:0] kind;
		logic       hit;
		kind = K_IDENT;
		if (s.wlen <= WLEN_W'(WORD_BUFFER_BYTES)) begin
			for (int i = KW_COUNT - 1; i >= 0; i--) begin
				hit = (KW_LEN[i] == s.wlen);
				for (int j = 0; j < KW_MAX_LEN; j++) begin
					if (WLEN_W'(j) < s.wlen && KW_TEXT[i][47-8*j -: 8] != s.word[j]) hit = 1'b0;
				end
				if (hit) kind = K_KW_FIRST + 6'(i);
			end
		end
		return kind;
	endfunction

	function automatic scan_st_t word_push(scan_st_t s, logic [7:0] c);
		for (int j = 0; j < WORD_BUFFER_BYTES; j++) begin
			if (s.wlen == WLEN_W'(j)) s.word[j] = c;
		end
		if (s.wlen <= WLEN_W'(WORD_BUFFER_BYTES)) s.wlen = s.wlen + WLEN_W'(1);
		return s;
	endfunction

	function automatic logic [5:0] punct_kind(logic [7:0] c);
		logic [5:0] k;
		case (c)
			"+": k = K_PLUS;
			"*": k = K_STAR;
			"=": k = K_EQUALS;
			";": k = K_SEMI;
			",": k = K_COMMA;
			":": k = K_COLON;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACKET;
			"]": k = K_RBRACKET;
			"<": k = K_LESS;
			">": k = K_GREATER;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic scan_st_t hold(scan_st_t s, logic [7:0] c);
		if (s.hcnt < 2'd2) begin
			s.held[s.hcnt[0]] = c;
			s.hcnt = s.hcnt + 2'd1;
		end
		return s;
	endfunction

	function automatic scan_st_t accept_held(scan_st_t s, logic [7:0] c);
		if (s.hcnt >= 2'd1) s = advance(s, s.held[0]);
		if (s.hcnt >= 2'd2) s = advance(s, s.held[1]);
		s.hcnt = 2'd0;
		s = advance(s, c);
		s.isf = 1'b1;
		return s;
	endfunction

	// One byte in every mode except the three lookahead modes, which the caller resolves.
	function automatic scan_work_t scan_simple(scan_work_t w, logic [7:0] c);
		logic again;
		logic [3:0] m;
		again = 1'b0;
		m = w.st.mode;
		case (m)
			M_LINE_C: begin
				w.st = advance(w.st, c);
				if (c == CH_LF) w.st.mode = M_IDLE;
			end
			M_BLOCK_C: begin
				w.st = advance(w.st, c);
				if (c == "*") w.st.mode = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				w.st = advance(w.st, c);
				if (c == "/") w.st.mode = M_IDLE;
				else if (c != "*") w.st.mode = M_BLOCK_C;
			end
			M_SLASH: begin
				if (c == "/") begin
					w.st = advance(w.st, c);
					w.st.mode = M_LINE_C;
				end else if (c == "*") begin
					w.st = advance(w.st, c);
					w.st.mode = M_BLOCK_C;
				end else begin
					w = emit_token(w, K_SLASH);
					again = 1'b1;
				end
			end
			M_MINUS: begin
				if (c == ">") begin
					w.st = advance(w.st, c);
					w = emit_token(w, K_ARROW);
					w.st.mode = M_IDLE;
				end else begin
					w = emit_token(w, K_MINUS);
					again = 1'b1;
				end
			end
			M_WORD: begin
				if (is_word_part(c)) begin
					w.st = advance(w.st, c);
					w.st = word_push(w.st, c);
				end else begin
					w = emit_token(w, word_kind(w.st));
					again = 1'b1;
				end
			end
			M_INT, M_FRAC, M_EXP_DIG: begin
				if (is_digit(c)) begin
					w.st = advance(w.st, c);
				end else if (m == M_INT && c == ".") begin
					w.st = hold(w.st, c);
					w.st.mode = M_DOT;
				end else if (m != M_EXP_DIG && (c == "e" || c == "E")) begin
					w.st = hold(w.st, c);
					w.st.mode = M_EXP_E;
				end else begin
					w = emit_token(w, w.st.isf ? K_FLOAT : K_INT);
					again = 1'b1;
				end
			end
			default: again = 1'b1;
		endcase
		if (again) begin
			w.st.mode = M_IDLE;
			if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
				w.st = advance(w.st, c);
			end else begin
				w.st.tb_off = w.st.off;
				w.st.tb_line = w.st.line;
				w.st.tb_col = w.st.col;
				w.st = advance(w.st, c);
				if (is_word_start(c)) begin
					w.st.wlen = '0;
					w.st = word_push(w.st, c);
					w.st.mode = M_WORD;
				end else if (is_digit(c)) begin
					w.st.isf = 1'b0;
					w.st.mode = M_INT;
				end else if (c == "/") begin
					w.st.mode = M_SLASH;
				end else if (c == "-") begin
					w.st.mode = M_MINUS;
				end else begin
					w = emit_token(w, punct_kind(c));
				end
			end
		end
		return w;
	endfunction

	// Ends a number and scans the lookahead bytes again from between tokens.
	function automatic scan_work_t rescan(scan_work_t w);
		logic [1:0][7:0] h;
		logic [1:0]      n;
		w = emit_token(w, w.st.isf ? K_FLOAT : K_INT);
		h = w.st.held;
		n = w.st.hcnt;
		w.st.hcnt = 2'd0;
		w.st.mode = M_IDLE;
		if (n >= 2'd1) w = scan_simple(w, h[0]);
		if (n >= 2'd2) w = scan_simple(w, h[1]);
		return w;
	endfunction

	function automatic logic is_look_mode(logic [3:0] m);
		return m == M_DOT || m == M_EXP_E || m == M_EXP_SIGN;
	endfunction

	function automatic scan_work_t scan_byte(scan_work_t w, logic [7:0] c);
		if (is_look_mode(w.st.mode)) begin
			if (is_digit(c)) begin
				w.st.mode = (w.st.mode == M_DOT) ? M_FRAC : M_EXP_DIG;
				w.st = accept_held(w.st, c);
			end else if (w.st.mode == M_EXP_E && (c == "+" || c == "-")) begin
				w.st = hold(w.st, c);
				w.st.mode = M_EXP_SIGN;
			end else begin
				w = rescan(w);
				w = scan_simple(w, c);
			end
		end else begin
			w = scan_simple(w, c);
		end
		return w;
	endfunction

	function automatic scan_work_t finish(scan_work_t w);
		if (is_look_mode(w.st.mode)) w = rescan(w);
		case (w.st.mode)
			M_SLASH: w = emit_token(w, K_SLASH);
			M_MINUS: w = emit_token(w, K_MINUS);
			M_WORD: w = emit_token(w, word_kind(w.st));
			M_INT, M_FRAC, M_EXP_DIG: w = emit_token(w, w.st.isf ? K_FLOAT : K_INT);
			default: ;
		endcase
		w.st.mode = M_IDLE;
		w.st.hcnt = 2'd0;
		w = emit(w, K_EOF, w.st.off, 24'd0, w.st.line, w.st.col);
		w.st.off = 24'd0;
		w.st.line = 16'd1;
		w.st.col = 16'd1;
		return w;
	endfunction

endpackage

>>> hdl/stok_core.sv
// Scanner state registers and the single-pass next-state and token logic.
`timescale 1ns / 1ps
module stok_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_source,
	output stok_pkg::tok_batch_t  batch
);
	import stok_pkg::*;

	scan_st_t   st_q;
	scan_work_t w;

	always_comb begin
		w.st = st_q;
		w.b = '0;
		if (end_of_source) w = finish(w);
		else w = scan_byte(w, char_byte);
	end

	assign batch = w.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (fire) begin
			st_q <= w.st;
		end
	end
endmodule

>>> hdl/stok_outq.sv
// Result register bank that hands out the tokens of one input beat in order.
`timescale 1ns / 1ps
module stok_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  stok_pkg::tok_batch_t  batch,
	input  logic                  out_stall,
	output logic                  out_valid,
	output stok_pkg::tok_rec_t    rec,
	output logic                  last,
	output logic                  ready
);
	import stok_pkg::*;

	tok_rec_t [MAX_RESULTS-1:0] rec_q;
	logic [2:0]                 cnt_q;
	logic [2:0]                 rd_q;
	logic                       fire_out;

	assign out_valid = rd_q < cnt_q;
	assign fire_out = out_valid && !out_stall;
	assign last = (rd_q + 3'd1) == cnt_q;
	assign rec = rec_q[rd_q[1:0]];
	// A new beat may enter when the bank is empty or empties in this cycle.
	assign ready = !out_valid || (fire_out && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q <= 3'd0;
		end else if (load) begin
			cnt_q <= batch.n;
			rd_q <= 3'd0;
		end else if (fire_out) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) rec_q <= batch.rec;
	end
endmodule

>>> hdl/source_tokenizer_top.sv
// Top level of the source tokenizer: byte beats in, token record beats out.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | char_byte, end_of_source
//  out     | from block| out_valid/out_stall| token_kind .. start_column, last_of_run
//
// A byte beat is taken every cycle while the output is not stalled and each beat
// yields at most one token; a beat with more stalls the input as its tokens drain.
// The first token of a beat appears in the cycle after it is taken.
// Reset returns the scanner between tokens at offset 0, line 1, column 1.
// A stall on the output holds the current token and, while tokens wait, the input.
`timescale 1ns / 1ps
module source_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic        last_of_run
);
	import stok_pkg::*;

	tok_batch_t batch;
	tok_rec_t   rec;
	logic       ready;
	logic       fire;

	assign fire = in_valid && ready;
	assign in_stall = !ready;

	stok_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.char_byte(char_byte),
		.end_of_source(end_of_source),
		.batch(batch)
	);

	stok_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.load(fire),
		.batch(batch),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.rec(rec),
		.last(last_of_run),
		.ready(ready)
	);

	assign token_kind = rec.kind;
	assign start_offset = rec.off;
	assign token_length = rec.len;
	assign start_line = rec.line;
	assign start_column = rec.col;
endmodule

>>> hdl/stok_checker.sv
// Port-level checks on the source tokenizer, bound to its top level.
`timescale 1ns / 1ps
module stok_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_source,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  token_kind,
	input logic [23:0] token_length,
	input logic        last_of_run
);
	import stok_pkg::*;

	// An end beat always produces at least the eof token in the next cycle.
	a_eof_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_source |=> out_valid)
		else $error("no token after end beat");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_EOF |-> last_of_run)
		else $error("eof is not the last token of its beat");

	a_eof_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_EOF |-> token_length == 24'd0)
		else $error("eof with nonzero length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");
endmodule

bind source_tokenizer_top stok_checker u_stok_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.end_of_source(end_of_source),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.token_kind(token_kind),
	.token_length(token_length),
	.last_of_run(last_of_run)
);

>>> tb/sv/source_tokenizer_top_tb.sv
// Self-checking testbench for the source tokenizer: directed table, then random source text.
`timescale 1ns / 1ps
module source_tokenizer_top_tb;
	import stok_pkg::*;

	typedef struct {
		logic [5:0]  kind;
		logic [23:0] off;
		logic [23:0] len;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} token_t;

	typedef struct {
		logic [7:0] ch;
		logic       eos;
		logic       known;
		token_t     tok;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_byte;
	logic        end_of_source;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  token_kind;
	logic [23:0] start_offset;
	logic [23:0] token_length;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        last_of_run;

	source_tokenizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_byte(char_byte), .end_of_source(end_of_source),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .start_offset(start_offset),
		.token_length(token_length), .start_line(start_line),
		.start_column(start_column), .last_of_run(last_of_run)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Scanner state of the predictor.
	logic [3:0]  lex_mode;
	logic [7:0]  look_bytes [2];
	int          look_cnt;
	logic [23:0] tok_off;
	logic [15:0] tok_line;
	logic [15:0] tok_col;
	logic [23:0] cur_off;
	logic [15:0] cur_line;
	logic [15:0] cur_col;
	logic [7:0]  word_buf [WORD_BUFFER_BYTES];
	int          word_len;
	logic        num_float;

	token_t      pending_tokens [$];
	token_t      step_tokens [$];
	int          errors;
	int          cycles;
	logic        quiet;

	function automatic logic digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic wstart(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic tok_differs(token_t a, token_t b);
		return a.kind !== b.kind || a.off !== b.off || a.len !== b.len ||
			a.line !== b.line || a.col !== b.col || a.last !== b.last;
	endfunction

	task automatic lex_reset();
		lex_mode = M_IDLE;
		look_cnt = 0;
		tok_off = 24'd0;
		tok_line = 16'd1;
		tok_col = 16'd1;
		cur_off = 24'd0;
		cur_line = 16'd1;
		cur_col = 16'd1;
		word_len = 0;
		num_float = 1'b0;
	endtask

	task automatic step_pos(logic [7:0] c);
		if (cur_off != 24'hFFFFFF) cur_off++;
		if (c == CH_LF) begin
			if (cur_line != 16'hFFFF) cur_line++;
			cur_col = 16'd1;
		end else if (cur_col != 16'hFFFF) begin
			cur_col++;
		end
	endtask

	task automatic push_tok(logic [5:0] k, logic [23:0] o, logic [23:0] l,
			logic [15:0] ln, logic [15:0] cl);
		token_t t;
		t.kind = k;
		t.off = o;
		t.len = l;
		t.line = ln;
		t.col = cl;
		t.last = 1'b0;
		if (step_tokens.size() < MAX_RESULTS) step_tokens.insert(step_tokens.size(), t);
	endtask

	task automatic close_tok(logic [5:0] k);
		push_tok(k, tok_off, (cur_off >= tok_off) ? cur_off - tok_off : 24'd0,
			tok_line, tok_col);
	endtask

	function automatic logic [5:0] classify_word();
		string s;
		string kws [12] = '{"fn", "let", "cast", "true", "false", "tensor",
			"f32", "f16", "bf16", "i32", "i8", "bool"};
		if (word_len > WORD_BUFFER_BYTES) return K_IDENT;
		s = "";
		for (int i = 0; i < word_len; i++) s = {s, string'(word_buf[i])};
		for (int i = 0; i < 12; i++) if (kws[i] == s) return K_KW_FIRST + 6'(i);
		return K_IDENT;
	endfunction

	task automatic add_word(logic [7:0] c);
		if (word_len < WORD_BUFFER_BYTES) word_buf[word_len] = c;
		if (word_len <= WORD_BUFFER_BYTES) word_len++;
	endtask

	function automatic logic [5:0] single_kind(logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"*": return K_STAR;
			"=": return K_EQUALS;
			";": return K_SEMI;
			",": return K_COMMA;
			":": return K_COLON;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"[": return K_LBRACKET;
			"]": return K_RBRACKET;
			"<": return K_LESS;
			">": return K_GREATER;
			default: return K_UNKNOWN;
		endcase
	endfunction

	task automatic take_look(logic [7:0] c);
		for (int i = 0; i < look_cnt; i++) step_pos(look_bytes[i]);
		look_cnt = 0;
		step_pos(c);
		num_float = 1'b1;
	endtask

	// Lexes one byte; lookahead bytes are lexed again after the number closes.
	task automatic lex_byte(logic [7:0] c);
		logic [7:0] h [2];
		int n;
		logic again;
		if (lex_mode == M_DOT || lex_mode == M_EXP_E || lex_mode == M_EXP_SIGN) begin
			if (digit(c)) begin
				lex_mode = (lex_mode == M_DOT) ? M_FRAC : M_EXP_DIG;
				take_look(c);
				return;
			end
			if (lex_mode == M_EXP_E && (c == "+" || c == "-")) begin
				look_bytes[look_cnt++] = c;
				lex_mode = M_EXP_SIGN;
				return;
			end
			close_tok(num_float ? K_FLOAT : K_INT);
			h = look_bytes;
			n = look_cnt;
			look_cnt = 0;
			lex_mode = M_IDLE;
			for (int i = 0; i < n; i++) lex_byte(h[i]);
		end
		again = 1'b0;
		case (lex_mode)
			M_LINE_C: begin
				step_pos(c);
				if (c == CH_LF) lex_mode = M_IDLE;
			end
			M_BLOCK_C: begin
				step_pos(c);
				if (c == "*") lex_mode = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				step_pos(c);
				if (c == "/") lex_mode = M_IDLE;
				else if (c != "*") lex_mode = M_BLOCK_C;
			end
			M_SLASH: begin
				if (c == "/" || c == "*") begin
					step_pos(c);
					lex_mode = (c == "/") ? M_LINE_C : M_BLOCK_C;
				end else begin
					close_tok(K_SLASH);
					again = 1'b1;
				end
			end
			M_MINUS: begin
				if (c == ">") begin
					step_pos(c);
					close_tok(K_ARROW);
					lex_mode = M_IDLE;
				end else begin
					close_tok(K_MINUS);
					again = 1'b1;
				end
			end
			M_WORD: begin
				if (wstart(c) || digit(c)) begin
					step_pos(c);
					add_word(c);
				end else begin
					close_tok(classify_word());
					again = 1'b1;
				end
			end
			M_INT, M_FRAC, M_EXP_DIG: begin
				if (digit(c)) begin
					step_pos(c);
				end else if (lex_mode == M_INT && c == ".") begin
					look_bytes[look_cnt++] = c;
					lex_mode = M_DOT;
				end else if (lex_mode != M_EXP_DIG && (c == "e" || c == "E")) begin
					look_bytes[look_cnt++] = c;
					lex_mode = M_EXP_E;
				end else begin
					close_tok(num_float ? K_FLOAT : K_INT);
					again = 1'b1;
				end
			end
			default: again = 1'b1;
		endcase
		if (again) begin
			lex_mode = M_IDLE;
			if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
				step_pos(c);
			end else begin
				tok_off = cur_off;
				tok_line = cur_line;
				tok_col = cur_col;
				step_pos(c);
				if (wstart(c)) begin
					word_len = 0;
					add_word(c);
					lex_mode = M_WORD;
				end else if (digit(c)) begin
					num_float = 1'b0;
					lex_mode = M_INT;
				end else if (c == "/") begin
					lex_mode = M_SLASH;
				end else if (c == "-") begin
					lex_mode = M_MINUS;
				end else begin
					close_tok(single_kind(c));
				end
			end
		end
	endtask

	// Expects the lookahead modes to be resolved already by the caller.
	task automatic lex_end();
		case (lex_mode)
			M_SLASH: close_tok(K_SLASH);
			M_MINUS: close_tok(K_MINUS);
			M_WORD: close_tok(classify_word());
			M_INT, M_FRAC, M_EXP_DIG: close_tok(num_float ? K_FLOAT : K_INT);
			default: ;
		endcase
		lex_mode = M_IDLE;
		look_cnt = 0;
		push_tok(K_EOF, cur_off, 24'd0, cur_line, cur_col);
		cur_off = 24'd0;
		cur_line = 16'd1;
		cur_col = 16'd1;
	endtask

	// Predicts the tokens of one beat and queues them in order.
	task automatic predict_beat(logic [7:0] c, logic eos);
		step_tokens.delete();
		if (eos) begin
			// The flush closes a pending number and rescans its lookahead bytes first.
			if (lex_mode == M_DOT || lex_mode == M_EXP_E || lex_mode == M_EXP_SIGN) begin
				logic [7:0] h [2];
				int n;
				close_tok(num_float ? K_FLOAT : K_INT);
				h = look_bytes;
				n = look_cnt;
				look_cnt = 0;
				lex_mode = M_IDLE;
				for (int i = 0; i < n; i++) lex_byte(h[i]);
			end
			lex_end();
		end else begin
			lex_byte(c);
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
	endtask

	// Output side: random stall bursts, checks each token beat.
	initial begin
		int burst;
		token_t e;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_tokens.size() == 0) begin
					$display("%0t: expected no token, actual kind %0d", $time, token_kind);
					errors++;
				end else begin
					e = pending_tokens.pop_front();
					if (token_kind !== e.kind || start_offset !== e.off ||
							token_length !== e.len || start_line !== e.line ||
							start_column !== e.col || last_of_run !== e.last) begin
						$display("%0t: expected k=%0d o=%0d l=%0d ln=%0d c=%0d last=%0b",
							$time, e.kind, e.off, e.len, e.line, e.col, e.last);
						$display("%0t: actual   k=%0d o=%0d l=%0d ln=%0d c=%0d last=%0b",
							$time, token_kind, start_offset, token_length, start_line,
							start_column, last_of_run);
						errors++;
					end
				end
			end
			@(negedge clk);
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 8) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send(logic [7:0] c, logic eos);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		end_of_source <= eos;
		do @(posedge clk); while (in_stall);
		predict_beat(c, eos);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
	endtask

	function automatic string pick_piece();
		string pieces [] = '{"fn", "let", "cast", "true", "false", "tensor", "f32",
			"f16", "bf16", "i32", "i8", "bool", "x", "tensors", "bf1", "_a9",
			"123", "4.5", "7.", "1e5", "2E+3", "9e-", "3.x", "6e+q", "0.25e-7",
			"->", "-", "/", "// c\n", "/* c */", "/**/", "+", "*", "=", ";",
			",", ":", "(", ")", "{", "}", "[", "]", "<", ">", "@", "\t", "\r",
			"\n", " ", "longidentifier"};
		return pieces[$urandom_range(0, pieces.size() - 1)];
	endfunction

	row_t table_rows [$];

	task automatic add_row(logic [7:0] c, logic eos, logic known, token_t t);
		row_t r;
		r.ch = c;
		r.eos = eos;
		r.known = known;
		r.tok = t;
		table_rows.insert(table_rows.size(), r);
	endtask

	initial begin
		token_t none;
		token_t e;
		token_t p;
		int items;
		string s;
		errors = 0;
		quiet = 1'b0;
		in_valid = 1'b0;
		char_byte = 8'h00;
		end_of_source = 1'b0;
		arst_n = 1'b0;
		lex_reset();
		none = '{default: '0};

		// End right after reset: eof at line 1, column 1.
		e = '{kind: K_EOF, off: 0, len: 0, line: 1, col: 1, last: 1};
		add_row(8'h00, 1'b1, 1'b1, e);
		e = '{kind: K_UNKNOWN, off: 0, len: 1, line: 1, col: 1, last: 1};
		add_row(8'hFF, 1'b0, 1'b1, e);
		e = '{kind: K_UNKNOWN, off: 1, len: 1, line: 1, col: 2, last: 1};
		add_row(8'h00, 1'b0, 1'b1, e);
		e = '{kind: K_PLUS, off: 2, len: 1, line: 1, col: 3, last: 1};
		add_row("+", 1'b0, 1'b1, e);
		s = "7.e+/*q";
		for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, none);
		add_row(8'h00, 1'b1, 1'b0, none);
		s = "bf16 8.e";
		for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, none);
		add_row(8'h00, 1'b1, 1'b0, none);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (table_rows[i]) begin
			send(table_rows[i].ch, table_rows[i].eos);
			if (table_rows[i].known) begin
				if (pending_tokens.size() == 0) begin
					$display("%0t: row %0d expected kind %0d, actual no token",
						$time, i, table_rows[i].tok.kind);
					errors++;
				end else begin
					p = pending_tokens[pending_tokens.size() - 1];
					if (tok_differs(p, table_rows[i].tok)) begin
						$display("%0t: row %0d expected k=%0d o=%0d l=%0d ln=%0d c=%0d",
							$time, i, table_rows[i].tok.kind, table_rows[i].tok.off,
							table_rows[i].tok.len, table_rows[i].tok.line,
							table_rows[i].tok.col);
						$display("%0t: row %0d actual   k=%0d o=%0d l=%0d ln=%0d c=%0d",
							$time, i, p.kind, p.off, p.len, p.line, p.col);
						errors++;
					end
				end
			end
		end

		// Random text from token-shaped pieces, with raw bytes and end beats mixed in.
		items = 0;
		while (items < 350) begin
			if (items > 300) quiet = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				send(8'($urandom_range(0, 255)), 1'b0);
				items++;
			end else if ($urandom_range(0, 24) == 0) begin
				send(8'h00, 1'b1);
				items++;
			end else begin
				s = pick_piece();
				send_text(s);
				items += s.len();
			end
		end
		send(8'h00, 1'b1);
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
hdl/stok_pkg.sv
hdl/stok_core.sv
hdl/stok_outq.sv
hdl/source_tokenizer_top.sv
hdl/stok_checker.sv
tb/sv/source_tokenizer_top_tb.sv
